FILE: rtl/bsn_pkg.sv
`timescale 1ns / 1ps

package bsn_pkg;

  localparam int WORDS     = 64;
  localparam int WORD_BITS = 32;

  localparam int WIDX_W = $clog2(WORDS);                 // word address
  localparam int BPOS_W = $clog2(WORD_BITS);             // bit position in a word
  localparam int CNT_W  = $clog2(WORD_BITS + 1);         // popcount of one word
  localparam int RANK_W = 12;
  localparam int USE_W  = 7;
  localparam int BIDX_W = 11;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SELECT = 1'b1;

  typedef struct packed {
    logic                 cmd;
    logic [WIDX_W-1:0]    word_index;
    logic [WORD_BITS-1:0] word_data;
    logic [RANK_W-1:0]    rank;
  } in_word_t;

  typedef struct packed {
    logic              found;
    logic [BIDX_W-1:0] bit_index;
  } out_word_t;

  typedef struct packed {
    logic                 start;
    logic [WORD_BITS-1:0] word;
    logic [CNT_W-1:0]     rank;
  } pick_req_t;

  typedef struct packed {
    logic              done;
    logic [BPOS_W-1:0] pos;
  } pick_res_t;

  function automatic logic [CNT_W-1:0] popcount(input logic [WORD_BITS-1:0] v);
    logic [CNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      c = c + CNT_W'(v[i]);
    end
    return c;
  endfunction

endpackage

FILE: rtl/bsn_pick.sv
`timescale 1ns / 1ps

module bsn_pick (
  input  logic               clk,
  input  logic               rst_n,
  input  bsn_pkg::pick_req_t req,
  output bsn_pkg::pick_res_t res
);
  import bsn_pkg::*;

  localparam int STEP_W = $clog2(BPOS_W + 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(BPOS_W - 1);
  localparam logic [BPOS_W-1:0] HALF      = BPOS_W'(WORD_BITS / 2);

  logic                 busy_r;
  logic [STEP_W-1:0]    step_r;
  logic [WORD_BITS-1:0] word_r, word_nxt;
  logic [CNT_W-1:0]     rank_r, rank_nxt;
  logic [BPOS_W-1:0]    pos_r, pos_nxt;
  logic [BPOS_W-1:0]    half_w;
  logic [WORD_BITS-1:0] mask_w;
  logic [CNT_W-1:0]     cnt_w;

  // binary search: count the low half of the window, then keep that half or skip it
  always_comb begin
    half_w   = HALF >> step_r;
    mask_w   = (WORD_BITS'(1) << half_w) - WORD_BITS'(1);
    cnt_w    = popcount(word_r & mask_w);
    word_nxt = word_r;
    rank_nxt = rank_r;
    pos_nxt  = pos_r;
    if (rank_r > cnt_w) begin
      word_nxt = word_r >> half_w;
      rank_nxt = rank_r - cnt_w;
      pos_nxt  = pos_r + half_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      step_r <= '0;
      word_r <= req.word;
      rank_r <= req.rank;
      pos_r  <= '0;
    end else if (busy_r) begin
      word_r <= word_nxt;
      rank_r <= rank_nxt;
      pos_r  <= pos_nxt;
      step_r <= step_r + STEP_W'(1);
      if (step_r == LAST_STEP) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign res.done = busy_r && (step_r == LAST_STEP);
  assign res.pos  = pos_nxt;

endmodule

FILE: rtl/bitmap_select_nth_set_bit_top.sv
`timescale 1ns / 1ps

// Bitmap of 64 words of 32 bits, all clear after reset, with a select that finds the
// global index of the nth set bit among the first words_in_use words. A write word
// (cmd 0) stores one bitmap word and produces no result. A select word (cmd 1) scans
// the bitmap memory from word 0, one word read and popcounted per cycle through its
// single read port, then resolves the bit inside the hit word in five halving steps.
// A select that hits, or that runs out of set bits over the searched words, keeps busy
// high until its result; a zero rank or zero words in use never raises it. The result
// shows on out_word for exactly one cycle under out_strobe, in the same cycle that busy
// falls, so busy is already low then; the receiver cannot stall it, so it must take
// every strobed word. cfg_data (words_in_use, above 64 treated as 64) is written while
// the block is idle; cfg_ready is low during a select.
module bitmap_select_nth_set_bit_top (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  bsn_pkg::in_word_t      in_word,
  output logic                   out_strobe,
  output bsn_pkg::out_word_t     out_word,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [bsn_pkg::USE_W-1:0] cfg_data
);
  import bsn_pkg::*;

  localparam int TOT_W = $clog2(WORDS * WORD_BITS + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_PICK} state_t;

  state_t               state_r;
  logic [USE_W-1:0]     words_in_use_r;
  logic [USE_W-1:0]     use_w;
  logic [WIDX_W-1:0]    w_r;
  logic [TOT_W-1:0]     total_r;
  logic [RANK_W-1:0]    rank_r;
  logic                 out_strobe_r;
  logic                 out_found_r;
  logic [BIDX_W-1:0]    out_idx_r;

  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORDS-1:0]     valid_r;
  logic [WORD_BITS-1:0] mem_q;
  logic                 valid_q;

  logic                 acc_wr, acc_sel, sel_empty;
  logic                 rd_en;
  logic [WIDX_W-1:0]    rd_addr;
  logic [WORD_BITS-1:0] word_cur;
  logic [CNT_W-1:0]     pop_cur;
  logic [TOT_W-1:0]     sum_cur;
  logic                 hit, last_word;
  pick_req_t            pick_req;
  pick_res_t            pick_res;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = !busy;
  assign use_w     = (words_in_use_r > USE_W'(WORDS)) ? USE_W'(WORDS) : words_in_use_r;

  always_comb begin
    acc_wr    = start && !busy && (in_word.cmd == CMD_WRITE);
    acc_sel   = start && !busy && (in_word.cmd == CMD_SELECT);
    sel_empty = (in_word.rank == '0) || (use_w == '0);
    // entries never written read as zero
    word_cur  = valid_q ? mem_q : '0;
    pop_cur   = popcount(word_cur);
    sum_cur   = total_r + TOT_W'(pop_cur);
    hit       = (RANK_W'(sum_cur) >= rank_r);
    last_word = ((USE_W'(w_r) + USE_W'(1)) == use_w);
    rd_en     = (acc_sel && !sel_empty) ||
                ((state_r == ST_SCAN) && !hit && !last_word);
    rd_addr   = (state_r == ST_SCAN) ? (w_r + WIDX_W'(1)) : '0;
    pick_req.start = (state_r == ST_SCAN) && hit;
    pick_req.word  = word_cur;
    pick_req.rank  = CNT_W'(rank_r - RANK_W'(total_r));
  end

  always_ff @(posedge clk) begin
    if (acc_wr) begin
      mem[in_word.word_index] <= in_word.word_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      valid_q <= 1'b0;
    end else begin
      if (acc_wr) begin
        valid_r[in_word.word_index] <= 1'b1;
      end
      if (rd_en) begin
        valid_q <= valid_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_in_use_r <= USE_W'(WORDS);
    end else if (cfg_valid && cfg_ready) begin
      words_in_use_r <= cfg_data;
    end
  end

  bsn_pick u_pick (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (pick_req),
    .res   (pick_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (acc_sel) begin
            if (sel_empty) begin
              out_strobe_r <= 1'b1;
              out_found_r  <= 1'b0;
              out_idx_r    <= '0;
            end else begin
              state_r <= ST_SCAN;
              w_r     <= '0;
              total_r <= '0;
              rank_r  <= in_word.rank;
            end
          end
        end
        ST_SCAN: begin
          if (hit) begin
            state_r <= ST_PICK;
          end else if (last_word) begin
            // ran out of searched words
            out_strobe_r <= 1'b1;
            out_found_r  <= 1'b0;
            out_idx_r    <= '0;
            state_r      <= ST_IDLE;
          end else begin
            w_r     <= w_r + WIDX_W'(1);
            total_r <= sum_cur;
          end
        end
        ST_PICK: begin
          if (pick_res.done) begin
            out_strobe_r <= 1'b1;
            out_found_r  <= 1'b1;
            out_idx_r    <= BIDX_W'({w_r, pick_res.pos});
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_strobe         = out_strobe_r;
  assign out_word.found     = out_found_r;
  assign out_word.bit_index = out_idx_r;

  a_pick_only_in_pick: assert property (@(posedge clk) disable iff (!rst_n)
    pick_res.done |-> (state_r == ST_PICK))
    else $error("pick unit finished outside the pick phase");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (USE_W'(w_r) < use_w))
    else $error("scan word beyond the words in use");

  a_miss_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_word.found) |-> (out_word.bit_index == '0))
    else $error("not-found result carries a nonzero bit index");

  a_write_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_word.cmd == CMD_WRITE)) |=> (!busy && !out_strobe))
    else $error("write word started a search or gave a result");

  a_pick_follows_hit: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) && hit) |=> (state_r == ST_PICK))
    else $error("hit in scan did not enter the pick phase");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import bsn_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int MODE_MIXED  = 0;
  localparam int MODE_DENSE  = 1;
  localparam int MODE_SPARSE = 2;

  // expected select answers against a private copy of the bitmap and words_in_use
  class bitmap_scoreboard;
    logic [WORD_BITS-1:0] bitmap [WORDS];
    logic [USE_W-1:0]     use_words;
    out_word_t            pending [$];
    int                   errors;

    function new();
      foreach (bitmap[i]) bitmap[i] = '0;
      use_words = USE_W'(64);
      errors = 0;
    endfunction

    function int unsigned search_limit();
      return (use_words > WORDS) ? WORDS : use_words;
    endfunction

    function int unsigned set_bits_in_use();
      int unsigned total;
      total = 0;
      for (int i = 0; i < search_limit(); i++) total += $countones(bitmap[i]);
      return total;
    endfunction

    function void note_input(in_word_t w);
      out_word_t   e;
      int unsigned seen;
      bit          hit;
      e = '0;
      seen = 0;
      hit = 1'b0;
      if (w.cmd == CMD_WRITE) begin
        bitmap[w.word_index] = w.word_data;
        return;
      end
      if (w.rank != 0) begin
        for (int wi = 0; wi < search_limit() && !hit; wi++) begin
          for (int b = 0; b < WORD_BITS && !hit; b++) begin
            if (bitmap[wi][b]) begin
              seen++;
              if (seen == w.rank) begin
                hit = 1'b1;
                e.found = 1'b1;
                e.bit_index = BIDX_W'(wi * WORD_BITS + b);
              end
            end
          end
        end
      end
      pending.push_back(e);
    endfunction

    task report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(input out_word_t got);
      out_word_t e;
      if (pending.size() == 0) begin
        report($sformatf("result word with nothing pending (found %0d index %0d)",
                         got.found, got.bit_index));
        return;
      end
      e = pending.pop_front();
      if (got.found !== e.found)
        report($sformatf("found %0d, expected %0d", got.found, e.found));
      if (got.bit_index !== e.bit_index)
        report($sformatf("bit_index %0d, expected %0d", got.bit_index, e.bit_index));
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  in_word_t          in_word;
  logic              out_strobe;
  out_word_t         out_word;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [USE_W-1:0]  cfg_data;

  bitmap_scoreboard  sb;
  int unsigned       cycle_count = 0;

  bitmap_select_nth_set_bit_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_word);
  end

  task automatic send_item(input in_word_t w);
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    sb.note_input(w);
  endtask

  task automatic maybe_idle(input bit allow);
    if (allow && $urandom_range(0, 99) < 30) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // stop sending and let every pending select come back
  task automatic settle(input int quiet);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (quiet) @(posedge clk);
  endtask

  task automatic write_words_in_use(input logic [USE_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.use_words = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic wr(input int idx, input logic [WORD_BITS-1:0] data);
    in_word_t w;
    w.cmd = CMD_WRITE;
    w.word_index = WIDX_W'(idx);
    w.word_data = data;
    w.rank = RANK_W'($urandom);
    send_item(w);
  endtask

  task automatic sel(input int unsigned rank);
    in_word_t w;
    w.cmd = CMD_SELECT;
    w.word_index = WIDX_W'($urandom);
    w.word_data = $urandom;
    w.rank = RANK_W'(rank);
    send_item(w);
  endtask

  function automatic logic [WORD_BITS-1:0] pick_data(input int mode);
    int r;
    r = $urandom_range(0, 9);
    case (mode)
      MODE_DENSE: begin
        return (r < 7) ? '1 : $urandom;
      end
      MODE_SPARSE: begin
        if (r < 6) return WORD_BITS'(1) << $urandom_range(0, WORD_BITS - 1);
        if (r < 8) return '0;
        return $urandom & $urandom;
      end
      default: begin
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r == 2) return WORD_BITS'(1) << $urandom_range(0, WORD_BITS - 1);
        if (r == 3) return $urandom & $urandom;
        return $urandom;
      end
    endcase
  endfunction

  task automatic random_item(input int mode);
    int unsigned total;
    int          r;
    int          idx;
    if ($urandom_range(0, 99) < 50) begin
      // bias part of the writes to the low words so short searches hit too
      idx = ($urandom_range(0, 9) < 3) ? $urandom_range(0, 3) : $urandom_range(0, WORDS - 1);
      wr(idx, pick_data(mode));
    end else begin
      total = sb.set_bits_in_use();
      r = $urandom_range(0, 99);
      if (total > 0 && r < 70) sel($urandom_range(1, total));
      else if (r < 85) sel(total + $urandom_range(0, 2));
      else if (r < 95) sel($urandom_range(0, 4095));
      else sel(0);
    end
  endtask

  int unsigned phase_use [7] = '{64, 1, 127, 0, 65, 0, 64};
  int          phase_len [7] = '{300, 100, 200, 60, 150, 250, 250};
  int          phase_mode [7] = '{MODE_MIXED, MODE_MIXED, MODE_DENSE, MODE_MIXED,
                                  MODE_MIXED, MODE_MIXED, MODE_SPARSE};

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty map, zero rank, first and last bit, rank past the end
    sel(1);
    sel(0);
    wr(0, 32'h0000_0001);
    sel(1);
    wr(63, 32'h8000_0000);
    sel(2);
    sel(3);
    wr(5, '1);
    sel(33);
    sel(34);
    sel(4095);
    wr(0, '0);
    sel(1);
    sel(0);
    settle(8);
    write_words_in_use(USE_W'(1));
    sel(1);
    wr(0, 32'h0001_0000);
    sel(1);
    sel(2);
    settle(8);
    write_words_in_use(USE_W'(0));
    sel(1);
    settle(8);
    // above the word count saturates to the full map
    write_words_in_use(USE_W'(127));
    wr(0, 32'h0000_0001);
    sel(34);
    sel(35);
    settle(8);

    for (int p = 0; p < 7; p++) begin
      write_words_in_use((p == 5) ? USE_W'($urandom_range(2, 63)) : USE_W'(phase_use[p]));
      if (phase_mode[p] == MODE_DENSE) begin
        for (int i = 0; i < WORDS; i++) wr(i, '1);
        sel(2048);
        sel(2049);
      end
      for (int i = 0; i < phase_len[p]; i++) begin
        random_item(phase_mode[p]);
        if (p == 0 && i == 150) settle(1);
        // no gaps in phase 5
        maybe_idle(p != 5);
      end
      settle(8);
    end

    settle(80);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: bitmap_select_nth_set_bit_top.f
rtl/bsn_pkg.sv
rtl/bsn_pick.sv
rtl/bitmap_select_nth_set_bit_top.sv
verif/tb_top.sv
